>>> rtl/core/fspc_pkg.sv
// Shared package for the five-stage core: ISA and port codes, widths,
// and the request structs passed between the pipeline, register file and data memory.
// No dependencies.
package fspc_pkg;

  localparam int unsigned DATA_WORDS_DEF = 256;
  localparam int unsigned NUM_REGS       = 8;
  localparam int unsigned REG_AW         = 3;
  localparam int unsigned XLEN           = 32;
  localparam int unsigned PC_W           = 16;
  localparam int unsigned IMM_W          = 6;
  localparam int unsigned IDX_W          = 8;

  // Transfer opcodes on the input channel
  typedef enum logic [2:0] {
    OP_INSTR  = 3'd0,
    OP_BUBBLE = 3'd1,
    OP_WR_REG = 3'd2,
    OP_WR_MEM = 3'd3,
    OP_RD_REG = 3'd4,
    OP_RD_MEM = 3'd5
  } op_t;

  // Instruction opcodes, bits 15..12
  localparam logic [3:0] IOP_RTYPE = 4'd0;
  localparam logic [3:0] IOP_LW    = 4'd4;
  localparam logic [3:0] IOP_SW    = 4'd5;
  localparam logic [3:0] IOP_ADDI  = 4'd8;
  localparam logic [3:0] IOP_BEQ   = 4'd9;

  // R-type funct codes
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_OR  = 3'd3;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [XLEN-1:0]   wdata;
    logic              id_en;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic              dir_en;
    logic [REG_AW-1:0] dir_idx;
  } rf_req_t;

  typedef struct packed {
    logic             st_en;
    logic             ld_en;
    logic [XLEN-1:0]  pipe_addr;
    logic [XLEN-1:0]  st_data;
    logic             dir_wr;
    logic             dir_rd;
    logic [IDX_W-1:0] dir_idx;
    logic [XLEN-1:0]  dir_data;
  } dm_req_t;

  typedef struct packed {
    logic              wb_en;
    logic [REG_AW-1:0] wb_reg;
    logic [XLEN-1:0]   wb_value;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic              ld_en;
    logic              st_en;
    logic [XLEN-1:0]   mem_addr;
    logic [XLEN-1:0]   st_data;
    logic              taken;
    logic [PC_W-1:0]   pc_nxt;
  } pipe_ctl_t;

endpackage

>>> rtl/core/five_stage_pipelined_cpu_core.sv
// Five-stage core: an instruction or bubble transfer advances the pipeline; a direct access does not.
// The result is registered and on out_* in the cycle after the input transfer; throughput one per cycle
// while out_ready is high, set by the single output register.
// Reset (rst_n low, synchronous): PC, pipeline latches, register file and data memory valid
// bits clear together; no clearing pass. Depends on fspc_pkg, fspc_pipe,
// fspc_regfile and fspc_dmem.
module five_stage_pipelined_cpu_core #(
  parameter int unsigned DATA_WORDS = fspc_pkg::DATA_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_opcode,
  input  logic [15:0]                        in_instr_word,
  input  logic [fspc_pkg::IDX_W-1:0]         in_target_index,
  input  logic signed [fspc_pkg::XLEN-1:0]   in_write_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fspc_pkg::PC_W-1:0]          out_fetch_pc,
  output logic                               out_branch_taken,
  output logic                               out_wb_valid,
  output logic [fspc_pkg::REG_AW-1:0]        out_wb_reg,
  output logic signed [fspc_pkg::XLEN-1:0]   out_wb_value,
  output logic signed [fspc_pkg::XLEN-1:0]   out_read_value
);
  import fspc_pkg::*;

  typedef enum logic [1:0] {
    RV_ZERO,
    RV_REG,
    RV_MEM
  } rv_src_t;

  op_t       op;
  logic      accept;
  logic      step;
  logic      fetch;
  logic      reg_ok;
  logic      rf_dir_wr;
  pipe_ctl_t ctl;
  rf_req_t   rf_req;
  dm_req_t   dm_req;

  logic [XLEN-1:0] rs_data, rt_data, rf_dir_data;
  logic [XLEN-1:0] ld_data, dm_dir_data;

  logic              out_valid_r;
  logic [PC_W-1:0]   fetch_pc_r;
  logic              taken_r;
  logic              wb_valid_r;
  logic [REG_AW-1:0] wb_reg_r;
  logic [XLEN-1:0]   wb_value_r;
  rv_src_t           rv_src_r, rv_src_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_opcode);
  assign step     = accept && (op == OP_INSTR || op == OP_BUBBLE);
  assign fetch    = accept && (op == OP_INSTR);
  assign reg_ok   = in_target_index < IDX_W'(NUM_REGS);

  always_comb begin
    rf_dir_wr        = accept && (op == OP_WR_REG) && reg_ok;
    rf_req.we        = ctl.wb_en || rf_dir_wr;
    rf_req.waddr     = ctl.wb_en ? ctl.wb_reg : in_target_index[REG_AW-1:0];
    rf_req.wdata     = ctl.wb_en ? ctl.wb_value : $unsigned(in_write_value);
    rf_req.id_en     = step;
    rf_req.rs        = ctl.rs;
    rf_req.rt        = ctl.rt;
    rf_req.dir_en    = accept && (op == OP_RD_REG) && reg_ok;
    rf_req.dir_idx   = in_target_index[REG_AW-1:0];

    dm_req.st_en     = ctl.st_en;
    dm_req.ld_en     = ctl.ld_en;
    dm_req.pipe_addr = ctl.mem_addr;
    dm_req.st_data   = ctl.st_data;
    dm_req.dir_wr    = accept && (op == OP_WR_MEM);
    dm_req.dir_rd    = accept && (op == OP_RD_MEM);
    dm_req.dir_idx   = in_target_index;
    dm_req.dir_data  = $unsigned(in_write_value);

    if (rf_req.dir_en) begin
      rv_src_nxt = RV_REG;
    end else if (dm_req.dir_rd) begin
      rv_src_nxt = RV_MEM;
    end else begin
      rv_src_nxt = RV_ZERO;
    end
  end

  fspc_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .fetch      (fetch),
    .instr_word (in_instr_word),
    .rs_data    (rs_data),
    .rt_data    (rt_data),
    .ld_data    (ld_data),
    .ctl        (ctl)
  );

  fspc_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (rf_req),
    .rs_data_r  (rs_data),
    .rt_data_r  (rt_data),
    .dir_data_r (rf_dir_data)
  );

  fspc_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (dm_req),
    .ld_data_r  (ld_data),
    .dir_data_r (dm_dir_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fetch_pc_r <= ctl.pc_nxt;
      taken_r    <= ctl.taken;
      wb_valid_r <= ctl.wb_en;
      wb_reg_r   <= ctl.wb_en ? ctl.wb_reg : '0;
      wb_value_r <= ctl.wb_en ? ctl.wb_value : '0;
      rv_src_r   <= rv_src_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fetch_pc     = fetch_pc_r;
  assign out_branch_taken = taken_r;
  assign out_wb_valid     = wb_valid_r;
  assign out_wb_reg       = wb_reg_r;
  assign out_wb_value     = $signed(wb_value_r);

  // direct read data stays in its read register until the next transfer
  always_comb begin
    unique case (rv_src_r)
      RV_REG:  out_read_value = $signed(rf_dir_data);
      RV_MEM:  out_read_value = $signed(dm_dir_data);
      default: out_read_value = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("transfer produced no result");
  a_wb_not_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wb_valid |-> out_wb_reg != '0)
    else $error("writeback to register 0 reported");
  a_direct_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (rv_src_r == RV_REG || rv_src_r == RV_MEM)
      |-> !out_wb_valid && !out_branch_taken)
    else $error("direct read advanced the pipeline");
`endif

endmodule

>>> rtl/core/fspc_regfile.sv
// Register file: 8 x 32 flops, one write port, two read ports with registered data.
// Reads see the same-cycle write first. Depends on fspc_pkg.
module fspc_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fspc_pkg::rf_req_t           req,
  output logic [fspc_pkg::XLEN-1:0]   rs_data_r,
  output logic [fspc_pkg::XLEN-1:0]   rt_data_r,
  output logic [fspc_pkg::XLEN-1:0]   dir_data_r
);
  import fspc_pkg::*;

  logic [XLEN-1:0]   regs_r [NUM_REGS];
  logic [REG_AW-1:0] port_b_addr;
  logic [XLEN-1:0]   rs_nxt;
  logic [XLEN-1:0]   port_b_nxt;

  always_comb begin
    port_b_addr = req.dir_en ? req.dir_idx : req.rt;
    rs_nxt      = (req.we && req.waddr == req.rs) ? req.wdata : regs_r[req.rs];
    port_b_nxt  = (req.we && req.waddr == port_b_addr) ? req.wdata : regs_r[port_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (req.we) begin
      regs_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.id_en) begin
      rs_data_r <= rs_nxt;
      rt_data_r <= port_b_nxt;
    end
    if (req.dir_en) begin
      dir_data_r <= port_b_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rf_write: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |=> regs_r[$past(req.waddr)] == $past(req.wdata))
    else $error("register write lost");
  a_rf_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.id_en && req.dir_en))
    else $error("decode read and direct read collide");
  a_rf_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    req.id_en && req.we && req.waddr == req.rs |=> rs_data_r == $past(req.wdata))
    else $error("decode read missed writeback value");
`endif

endmodule

>>> rtl/core/fspc_dmem.sv
// Data memory: DATA_WORDS x 32 array, one write port, one read port with registered data
// into a load register and a direct-read register; valid bits model the zero reset.
// Depends on fspc_pkg.
module fspc_dmem #(
  parameter int unsigned DATA_WORDS = fspc_pkg::DATA_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fspc_pkg::dm_req_t           req,
  output logic [fspc_pkg::XLEN-1:0]   ld_data_r,
  output logic [fspc_pkg::XLEN-1:0]   dir_data_r
);
  import fspc_pkg::*;

  localparam int unsigned AW = $clog2(DATA_WORDS);
  localparam int unsigned SW = AW + 2;
  localparam logic [SW-1:0] TWO_D = SW'(2 * DATA_WORDS);
  localparam logic [SW-1:0] ONE_D = SW'(DATA_WORDS);

  // (b << sh) mod DATA_WORDS for every byte value b
  function automatic logic [256*AW-1:0] mod_tbl(input int unsigned sh);
    logic [256*AW-1:0] t;
    longint unsigned   v;
    t = '0;
    for (int b = 0; b < 256; b++) begin
      v = (longint'(b) << sh) % DATA_WORDS;
      t[b*AW +: AW] = AW'(v);
    end
    return t;
  endfunction

  localparam logic [256*AW-1:0] MOD_T0 = mod_tbl(0);
  localparam logic [256*AW-1:0] MOD_T1 = mod_tbl(8);
  localparam logic [256*AW-1:0] MOD_T2 = mod_tbl(16);
  localparam logic [256*AW-1:0] MOD_T3 = mod_tbl(24);

  // byte-wise fold, then at most two corrections
  function automatic logic [AW-1:0] word_addr(input logic [XLEN-1:0] x);
    logic [SW-1:0] s;
    s = SW'(MOD_T0[x[7:0]*AW +: AW]) + SW'(MOD_T1[x[15:8]*AW +: AW])
      + SW'(MOD_T2[x[23:16]*AW +: AW]) + SW'(MOD_T3[x[31:24]*AW +: AW]);
    if (s >= TWO_D) begin
      s = s - TWO_D;
    end
    if (s >= ONE_D) begin
      s = s - ONE_D;
    end
    return AW'(s);
  endfunction

  logic [XLEN-1:0]       mem_r [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_r;
  logic [AW-1:0]         pipe_addr;
  logic [AW-1:0]         idx_addr;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [XLEN-1:0]       wdata;
  logic                  we;

  always_comb begin
    pipe_addr = word_addr(req.pipe_addr);
    idx_addr  = MOD_T0[req.dir_idx*AW +: AW];
    we        = req.st_en || req.dir_wr;
    waddr     = req.dir_wr ? idx_addr : pipe_addr;
    wdata     = req.dir_wr ? req.dir_data : req.st_data;
    raddr     = req.dir_rd ? idx_addr : pipe_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (req.ld_en) begin
      ld_data_r <= vld_r[raddr] ? mem_r[raddr] : '0;
    end
    if (req.dir_rd) begin
      dir_data_r <= vld_r[raddr] ? mem_r[raddr] : '0;
    end
  end

`ifndef SYNTHESIS
  a_dm_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && (req.ld_en || req.dir_rd)))
    else $error("data memory read and write collide");
  a_dm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!we || (waddr < ONE_D[AW:0]))
      && (!(req.ld_en || req.dir_rd) || (raddr < ONE_D[AW:0])))
    else $error("data address out of range");
  a_dm_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> vld_r[$past(waddr)])
    else $error("valid bit not set after write");
`endif

endmodule

>>> rtl/core/fspc_pipe.sv
// Pipeline control: PC, IF/ID, ID/EX, EX/MEM and MEM/WB latches, decode and ALU.
// Operand data lives in fspc_regfile, load data in fspc_dmem. Depends on fspc_pkg.
module fspc_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        fetch,
  input  logic [15:0]                 instr_word,
  input  logic [fspc_pkg::XLEN-1:0]   rs_data,
  input  logic [fspc_pkg::XLEN-1:0]   rt_data,
  input  logic [fspc_pkg::XLEN-1:0]   ld_data,
  output fspc_pkg::pipe_ctl_t         ctl
);
  import fspc_pkg::*;

  typedef struct packed {
    logic            vld;
    logic [15:0]     word;
    logic [PC_W-1:0] pc;
  } fd_t;

  typedef struct packed {
    logic              vld;
    logic              rw;
    logic              mr;
    logic              mw;
    logic              br;
    logic              use_imm;
    logic [IMM_W-1:0]  imm;
    logic [REG_AW-1:0] dest;
    logic [2:0]        alu;
    logic [PC_W-1:0]   pc;
  } de_t;

  typedef struct packed {
    logic              vld;
    logic              rw;
    logic              mr;
    logic              mw;
    logic              br;
    logic              zero;
    logic [XLEN-1:0]   result;
    logic [XLEN-1:0]   store;
    logic [REG_AW-1:0] dest;
    logic [PC_W-1:0]   target;
  } em_t;

  typedef struct packed {
    logic              vld;
    logic              rw;
    logic              mr;
    logic [XLEN-1:0]   result;
    logic [REG_AW-1:0] dest;
  } mw_t;

  logic [PC_W-1:0] pc_r, pc_nxt;
  fd_t fd_r, fd_nxt;
  de_t de_r, de_nxt;
  em_t em_r, em_nxt;
  mw_t mw_r, mw_nxt;

  logic [3:0]      iop;
  logic [XLEN-1:0] opnd;
  logic [XLEN-1:0] alu_out;
  logic            taken;

  // WB and MEM
  always_comb begin
    taken          = em_r.vld && em_r.br && em_r.zero;
    ctl.wb_en      = step && mw_r.vld && mw_r.rw && (mw_r.dest != '0);
    ctl.wb_reg     = mw_r.dest;
    ctl.wb_value   = mw_r.mr ? ld_data : mw_r.result;
    ctl.ld_en      = step && em_r.vld && em_r.mr;
    ctl.st_en      = step && em_r.vld && em_r.mw && !em_r.mr;
    ctl.mem_addr   = em_r.result;
    ctl.st_data    = em_r.store;
    ctl.taken      = step && taken;
    mw_nxt.vld     = em_r.vld;
    mw_nxt.rw      = em_r.vld && em_r.rw;
    mw_nxt.mr      = em_r.vld && em_r.mr;
    mw_nxt.result  = em_r.result;
    mw_nxt.dest    = em_r.dest;
  end

  // EX
  always_comb begin
    opnd = de_r.use_imm ? XLEN'(de_r.imm) : rt_data;
    unique case (de_r.alu)
      ALU_ADD: alu_out = rs_data + opnd;
      ALU_SUB: alu_out = rs_data - opnd;
      ALU_AND: alu_out = rs_data & opnd;
      ALU_OR:  alu_out = rs_data | opnd;
      default: alu_out = '0;
    endcase
    em_nxt.vld    = de_r.vld;
    em_nxt.rw     = de_r.vld && de_r.rw;
    em_nxt.mr     = de_r.vld && de_r.mr;
    em_nxt.mw     = de_r.vld && de_r.mw;
    em_nxt.br     = de_r.vld && de_r.br;
    em_nxt.zero   = (rs_data == rt_data);
    em_nxt.result = alu_out;
    em_nxt.store  = rt_data;
    em_nxt.dest   = de_r.dest;
    em_nxt.target = de_r.pc + PC_W'(1) + PC_W'(de_r.imm);
  end

  // ID
  always_comb begin
    iop            = fd_r.word[15:12];
    ctl.rs         = fd_r.word[11:9];
    ctl.rt         = fd_r.word[8:6];
    de_nxt.vld     = fd_r.vld;
    de_nxt.rw      = 1'b0;
    de_nxt.mr      = 1'b0;
    de_nxt.mw      = 1'b0;
    de_nxt.br      = 1'b0;
    de_nxt.use_imm = 1'b0;
    de_nxt.imm     = fd_r.word[IMM_W-1:0];
    de_nxt.dest    = fd_r.word[8:6];
    de_nxt.alu     = ALU_ADD;
    de_nxt.pc      = fd_r.pc;
    if (fd_r.vld) begin
      unique case (iop)
        IOP_RTYPE: begin
          de_nxt.rw   = 1'b1;
          de_nxt.alu  = fd_r.word[2:0];
          de_nxt.dest = fd_r.word[5:3];
        end
        IOP_ADDI: begin
          de_nxt.rw      = 1'b1;
          de_nxt.use_imm = 1'b1;
        end
        IOP_LW: begin
          de_nxt.rw      = 1'b1;
          de_nxt.mr      = 1'b1;
          de_nxt.use_imm = 1'b1;
        end
        IOP_SW: begin
          de_nxt.mw      = 1'b1;
          de_nxt.use_imm = 1'b1;
        end
        IOP_BEQ: begin
          de_nxt.br = 1'b1;
        end
        default: begin
          de_nxt.rw = 1'b0;
        end
      endcase
    end
  end

  // IF
  always_comb begin
    fd_nxt.vld  = 1'b0;
    fd_nxt.word = instr_word;
    fd_nxt.pc   = pc_r;
    pc_nxt      = pc_r;
    if (step) begin
      if (taken) begin
        pc_nxt = em_r.target;
      end else if (fetch) begin
        fd_nxt.vld = 1'b1;
        pc_nxt     = pc_r + PC_W'(1);
      end
    end
    ctl.pc_nxt = pc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      fd_r <= '0;
      de_r <= '0;
      em_r <= '0;
      mw_r <= '0;
    end else if (step) begin
      pc_r <= pc_nxt;
      fd_r <= fd_nxt;
      de_r <= de_nxt;
      em_r <= em_nxt;
      mw_r <= mw_nxt;
    end
  end

endmodule

>>> sim/five_stage_pipelined_cpu_core_tb.sv
// Self-checking testbench for five_stage_pipelined_cpu_core: directed and random
// instruction, bubble and direct-access transfers, with random stalls on both channels.
// Depends on fspc_pkg and the core RTL.
module five_stage_pipelined_cpu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fspc_pkg::*;

  localparam int unsigned DATA_WORDS = DATA_WORDS_DEF;
  localparam logic [3:0] IOP_JUMP = 4'd2;
  localparam logic [2:0] FN_ZERO_HI = 3'd7;

  typedef struct packed {
    logic [PC_W-1:0] fetch_pc;
    logic            branch_taken;
    logic            wb_valid;
    logic [2:0]      wb_reg;
    logic [31:0]     wb_value;
    logic [31:0]     read_value;
  } core_result_t;

  typedef struct packed {
    logic            valid;
    logic [15:0]     word;
    logic [PC_W-1:0] pc;
  } fetch_slot_t;

  typedef struct packed {
    logic             valid, rf_we, is_load, is_store, branch, use_imm;
    logic [31:0]      a, b;
    logic [IMM_W-1:0] imm;
    logic [2:0]       dest, alu;
    logic [PC_W-1:0]  pc;
  } decode_slot_t;

  typedef struct packed {
    logic            valid, rf_we, is_load, is_store, branch, zero;
    logic [31:0]     result, store;
    logic [2:0]      dest;
    logic [PC_W-1:0] target;
  } exec_slot_t;

  typedef struct packed {
    logic        valid, rf_we, is_load;
    logic [31:0] result, loaded;
    logic [2:0]  dest;
  } mem_slot_t;

  class core_checker;
    logic [31:0]     regs [NUM_REGS];
    logic [31:0]     dmem [DATA_WORDS];
    logic [PC_W-1:0] pc;
    fetch_slot_t     fd;
    decode_slot_t    de;
    exec_slot_t      em;
    mem_slot_t       mw;
    core_result_t    due_results[$];
    int mismatches, n_checked, n_taken, n_writebacks, n_direct;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      fd = '0;
      de = '0;
      em = '0;
      mw = '0;
    endfunction

    function void note_input(logic [2:0] op, logic [15:0] word, logic [7:0] idx,
                             logic [31:0] wval);
      core_result_t r;
      fetch_slot_t  nf;
      decode_slot_t nd;
      exec_slot_t   ne;
      mem_slot_t    nm;
      logic [PC_W-1:0] target;
      logic [31:0]  y;
      r = '0;
      target = '0;
      case (op)
        OP_INSTR, OP_BUBBLE: begin
          if (mw.valid && mw.rf_we && mw.dest != 3'd0) begin
            r.wb_valid = 1'b1;
            r.wb_reg = mw.dest;
            r.wb_value = mw.is_load ? mw.loaded : mw.result;
            regs[mw.dest] = r.wb_value;
          end
          nm = '0;
          if (em.valid) begin
            nm.valid = 1'b1;
            nm.rf_we = em.rf_we;
            nm.is_load = em.is_load;
            nm.result = em.result;
            nm.dest = em.dest;
            if (em.is_load) nm.loaded = dmem[em.result % DATA_WORDS];
            else if (em.is_store) dmem[em.result % DATA_WORDS] = em.store;
            if (em.branch && em.zero) begin
              r.branch_taken = 1'b1;
              target = em.target;
            end
          end
          ne = '0;
          if (de.valid) begin
            ne.valid = 1'b1;
            ne.rf_we = de.rf_we;
            ne.is_load = de.is_load;
            ne.is_store = de.is_store;
            ne.branch = de.branch;
            ne.zero = (de.a == de.b);
            y = de.use_imm ? 32'(de.imm) : de.b;
            case (de.alu)
              ALU_ADD: ne.result = de.a + y;
              ALU_SUB: ne.result = de.a - y;
              ALU_AND: ne.result = de.a & y;
              ALU_OR:  ne.result = de.a | y;
              default: ne.result = '0;
            endcase
            ne.store = de.b;
            ne.dest = de.dest;
            ne.target = de.pc + 16'd1 + 16'(de.imm);
          end
          nd = '0;
          if (fd.valid) begin
            nd.valid = 1'b1;
            nd.pc = fd.pc;
            nd.a = regs[fd.word[11:9]];
            nd.b = regs[fd.word[8:6]];
            nd.imm = fd.word[5:0];
            nd.dest = fd.word[8:6];
            nd.alu = ALU_ADD;
            case (fd.word[15:12])
              IOP_RTYPE: begin
                nd.rf_we = 1'b1;
                nd.alu = fd.word[2:0];
                nd.dest = fd.word[5:3];
              end
              IOP_ADDI: begin
                nd.rf_we = 1'b1;
                nd.use_imm = 1'b1;
              end
              IOP_LW: begin
                nd.rf_we = 1'b1;
                nd.is_load = 1'b1;
                nd.use_imm = 1'b1;
              end
              IOP_SW: begin
                nd.is_store = 1'b1;
                nd.use_imm = 1'b1;
              end
              IOP_BEQ: nd.branch = 1'b1;
              default: ;
            endcase
          end
          nf = '0;
          if (r.branch_taken) begin
            pc = target;
          end else if (op == OP_INSTR) begin
            nf.valid = 1'b1;
            nf.word = word;
            nf.pc = pc;
            pc = pc + 16'd1;
          end
          mw = nm;
          em = ne;
          de = nd;
          fd = nf;
        end
        OP_WR_REG: if (idx < NUM_REGS) regs[idx[2:0]] = wval;
        OP_WR_MEM: dmem[idx % DATA_WORDS] = wval;
        OP_RD_REG: r.read_value = (idx < NUM_REGS) ? regs[idx[2:0]] : '0;
        OP_RD_MEM: r.read_value = dmem[idx % DATA_WORDS];
        default: ;
      endcase
      r.fetch_pc = pc;
      if (op != OP_INSTR && op != OP_BUBBLE) n_direct++;
      if (r.branch_taken) n_taken++;
      if (r.wb_valid) n_writebacks++;
      due_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
    endtask

    task check_result(core_result_t got);
      core_result_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        report("unexpected transfer, fetch_pc", got.fetch_pc, '0);
      end else begin
        want = due_results.pop_front();
        if (got.fetch_pc !== want.fetch_pc) report("fetch_pc", got.fetch_pc, want.fetch_pc);
        if (got.branch_taken !== want.branch_taken)
          report("branch_taken", got.branch_taken, want.branch_taken);
        if (got.wb_valid !== want.wb_valid) report("wb_valid", got.wb_valid, want.wb_valid);
        if (got.wb_reg !== want.wb_reg) report("wb_reg", got.wb_reg, want.wb_reg);
        if (got.wb_value !== want.wb_value) report("wb_value", got.wb_value, want.wb_value);
        if (got.read_value !== want.read_value)
          report("read_value", got.read_value, want.read_value);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [15:0] in_instr_word;
  logic [IDX_W-1:0] in_target_index;
  logic signed [XLEN-1:0] in_write_value;
  logic        out_valid;
  logic        out_ready;
  logic [PC_W-1:0] out_fetch_pc;
  logic        out_branch_taken;
  logic        out_wb_valid;
  logic [REG_AW-1:0] out_wb_reg;
  logic signed [XLEN-1:0] out_wb_value;
  logic signed [XLEN-1:0] out_read_value;

  core_checker sb = new();
  int  in_left = 0, out_left = 0;
  bit  in_quick = 1'b0, out_quick = 1'b1;

  five_stage_pipelined_cpu_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_instr_word    (in_instr_word),
    .in_target_index  (in_target_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fetch_pc     (out_fetch_pc),
    .out_branch_taken (out_branch_taken),
    .out_wb_valid     (out_wb_valid),
    .out_wb_reg       (out_wb_reg),
    .out_wb_value     (out_wb_value),
    .out_read_value   (out_read_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    core_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_opcode, in_instr_word, in_target_index, in_write_value);
      if (out_valid && out_ready) begin
        got.fetch_pc = out_fetch_pc;
        got.branch_taken = out_branch_taken;
        got.wb_valid = out_wb_valid;
        got.wb_reg = out_wb_reg;
        got.wb_value = out_wb_value;
        got.read_value = out_read_value;
        sb.check_result(got);
      end
    end
  end

  // alternating stretches of random idling and back-to-back transfers
  function automatic int pick_gap(inout int left, inout bit quick);
    if (left == 0) begin
      quick = !quick;
      left = $urandom_range(8, 40);
    end
    left--;
    return quick ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [15:0] mk_word(logic [3:0] iop, logic [2:0] rs, logic [2:0] rt,
                                          logic [5:0] low);
    return {iop, rs, rt, low};
  endfunction

  function automatic logic [15:0] random_instr();
    logic [15:0] w;
    int pick;
    w = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) w[15:12] = IOP_RTYPE;
    else if (pick < 48) w[15:12] = IOP_ADDI;
    else if (pick < 63) w[15:12] = IOP_LW;
    else if (pick < 77) w[15:12] = IOP_SW;
    else if (pick < 90) w[15:12] = IOP_BEQ;
    if (w[15:12] == IOP_BEQ && $urandom_range(0, 1) == 1) w[8:6] = w[11:9];
    return w;
  endfunction

  function automatic logic [31:0] random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 32'($urandom_range(0, 31));
    if (pick == 4) return 32'h7FFF_FFFF;
    if (pick == 5) return 32'h8000_0000;
    if (pick == 6) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_item(op_t op, logic [15:0] word, logic [7:0] idx, logic [31:0] val);
    int gap;
    gap = pick_gap(in_left, in_quick);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_instr_word <= word;
    in_target_index <= idx;
    in_write_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_pipe(op_t op, logic [15:0] word);
    send_item(op, word, 8'($urandom), $urandom);
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap(out_left, out_quick);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #2_000_000;
    $display("five_stage_pipelined_cpu_core_tb NOT OK");
    $finish;
  end

  initial begin
    int sel;
    op_t op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_BUBBLE;
    in_instr_word = '0;
    in_target_index = '0;
    in_write_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // direct access corners: register 0, out-of-range index, address extremes
    send_item(OP_WR_REG, 16'h0000, 8'd0, 32'h1234_5678);
    send_item(OP_WR_REG, 16'hFFFF, 8'd1, 32'h7FFF_FFFF);
    send_item(OP_WR_REG, 16'h0000, 8'd2, 32'hFFFF_FFFF);
    send_item(OP_WR_REG, 16'h0000, 8'd3, 32'h8000_0000);
    send_item(OP_WR_REG, 16'h0000, 8'd255, 32'hFFFF_FFFF);
    send_item(OP_RD_REG, 16'h0000, 8'd255, 32'h0);
    send_item(OP_WR_MEM, 16'h0000, 8'd255, 32'hDEAD_BEEF);
    send_item(OP_WR_MEM, 16'h0000, 8'd0, 32'h0000_0001);
    send_item(OP_RD_MEM, 16'h0000, 8'd255, 32'h0);
    // every ALU op, zero functs, R0 destination, wrapping immediates, taken branch
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd1, 3'd2, {3'd4, ALU_ADD}));
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd3, 3'd1, {3'd5, ALU_SUB}));
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd2, 3'd3, {3'd6, ALU_AND}));
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd1, 3'd3, {3'd7, ALU_OR}));
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd1, 3'd2, {3'd1, FN_ZERO_HI}));
    send_pipe(OP_INSTR, mk_word(IOP_RTYPE, 3'd1, 3'd1, {3'd0, ALU_ADD}));
    send_pipe(OP_INSTR, mk_word(IOP_ADDI, 3'd1, 3'd2, 6'd63));
    send_pipe(OP_INSTR, mk_word(IOP_LW, 3'd2, 3'd5, 6'd1));
    send_pipe(OP_INSTR, mk_word(IOP_SW, 3'd0, 3'd7, 6'd63));
    send_pipe(OP_INSTR, mk_word(IOP_BEQ, 3'd3, 3'd3, 6'd5));
    send_pipe(OP_INSTR, mk_word(IOP_JUMP, 3'd7, 3'd7, 6'd63));
    send_pipe(OP_INSTR, 16'hFFFF);
    repeat (3) send_pipe(OP_BUBBLE, 16'($urandom));
    send_item(OP_RD_MEM, 16'h0000, 8'hB7, 32'h0);
    wait_drained();

    for (int k = 0; k < 500; k++) begin
      if ($urandom_range(0, 99) == 0) wait_drained();
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_pipe(OP_INSTR, random_instr());
      end else if (sel < 78) begin
        send_pipe(OP_BUBBLE, 16'($urandom));
      end else begin
        op = op_t'($urandom_range(OP_WR_REG, OP_RD_MEM));
        send_item(op, 16'($urandom),
                  ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                  random_value());
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d transfers (%0d direct accesses, %0d writebacks, %0d taken branches)",
             sb.n_checked, sb.n_direct, sb.n_writebacks, sb.n_taken);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("five_stage_pipelined_cpu_core_tb OK");
    else
      $display("five_stage_pipelined_cpu_core_tb NOT OK");
    $finish;
  end

endmodule

>>> five_stage_pipelined_cpu_core.f
rtl/core/fspc_pkg.sv
rtl/core/fspc_regfile.sv
rtl/core/fspc_dmem.sv
rtl/core/fspc_pipe.sv
rtl/core/five_stage_pipelined_cpu_core.sv
sim/five_stage_pipelined_cpu_core_tb.sv
